>>> design/top_magnitude_matrix_sparsifier_defines.svh
// Assertion macros shared by the sparsifier RTL.
// Depends on nothing; the including module supplies clock and reset.
`ifndef TOP_MAGNITUDE_MATRIX_SPARSIFIER_DEFINES_SVH
`define TOP_MAGNITUDE_MATRIX_SPARSIFIER_DEFINES_SVH

// Clocked check, disabled while reset is high.
`define TMMS_CHECK(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Check that a condition implies another one in the following cycle.
`define TMMS_CHECK_NEXT(lbl, cond, nxt, msg) \
   `TMMS_CHECK(lbl, (cond) |=> (nxt), msg)

`endif

>>> design/tmms_pkg.sv
// Package for the top-magnitude matrix sparsifier: widths, reset values,
// register indexes, state codes and the sort link type. Depends on nothing.
package tmms_pkg;

   localparam int DEF_MAX_DIM    = 8;
   localparam int DEF_VALUE_BITS = 32;

   localparam int DIM_W      = 4;
   localparam int KEEP_W     = 7;
   localparam int CSR_DATA_W = 7;

   localparam int DIM_RESET  = 8;
   localparam int KEEP_RESET = 64;

   typedef enum logic [0:0] {
      CSR_MATRIX_DIM = 1'b0,
      CSR_KEEP_COUNT = 1'b1
   } csr_index_type;

   typedef enum logic [1:0] {
      ST_LOAD,
      ST_RANK,
      ST_EMIT
   } tmms_state_type;

   // Flags one sort cell hands to the next one down the row.
   typedef struct packed {
      logic valid;   // cell holds a magnitude of the current matrix
      logic gt;      // incoming magnitude ranks above this cell's
   } sort_flag_type;

endpackage

>>> design/tmms_cell.sv
// One cell of the sparsifier row: an insertion-sort slot for magnitudes and
// one tap of the entry shift line. Depends on tmms_pkg.
module tmms_cell #(
   parameter int VALUE_BITS = 32
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    restart,
   input  logic                    insert,
   input  logic                    shift_en,
   input  logic [VALUE_BITS-2:0]   new_mag,
   input  tmms_pkg::sort_flag_type up_flag,
   input  logic [VALUE_BITS-2:0]   up_sort_mag,
   output tmms_pkg::sort_flag_type dn_flag,
   output logic [VALUE_BITS-2:0]   dn_sort_mag,
   input  logic [VALUE_BITS-1:0]   up_ent_value,
   input  logic [VALUE_BITS-2:0]   up_ent_mag,
   output logic [VALUE_BITS-1:0]   dn_ent_value,
   output logic [VALUE_BITS-2:0]   dn_ent_mag
);
   import tmms_pkg::*;

   localparam int MAG_W = VALUE_BITS - 1;

   logic             valid_ff, valid_in;
   logic [MAG_W-1:0] sort_mag_ff, sort_mag_in;
   logic [VALUE_BITS-1:0] ent_value_ff, ent_value_in;
   logic [MAG_W-1:0]      ent_mag_ff, ent_mag_in;
   logic             eff_valid;
   logic             gt;

   // A new matrix forgets every held magnitude.
   assign eff_valid = valid_ff & ~restart;
   assign gt        = ~eff_valid | (new_mag > sort_mag_ff);

   assign dn_flag.valid = eff_valid;
   assign dn_flag.gt    = gt;
   assign dn_sort_mag   = sort_mag_ff;
   assign dn_ent_value  = ent_value_ff;
   assign dn_ent_mag    = ent_mag_ff;

   always_comb begin
      valid_in     = valid_ff;
      sort_mag_in  = sort_mag_ff;
      ent_value_in = ent_value_ff;
      ent_mag_in   = ent_mag_ff;
      if (insert) begin
         valid_in = eff_valid | up_flag.valid;
         // below the insert point take the neighbor's value, at it the new one
         if (gt) begin
            sort_mag_in = up_flag.gt ? up_sort_mag : new_mag;
         end
      end
      if (shift_en) begin
         ent_value_in = up_ent_value;
         ent_mag_in   = up_ent_mag;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      sort_mag_ff  <= sort_mag_in;
      ent_value_ff <= ent_value_in;
      ent_mag_ff   <= ent_mag_in;
   end

endmodule

>>> design/top_magnitude_matrix_sparsifier.sv
// Top level of the top-magnitude matrix sparsifier: control, threshold
// selection and output register around a row of tmms_cell instances.
// Depends on tmms_pkg, tmms_cell and top_magnitude_matrix_sparsifier_defines.svh.
//
// Usage: write matrix_dim (index 0) and keep_count (index 1) through the csr
// port while busy is low; writing matrix_dim drops a partly loaded matrix. Then
// pulse start with one entry per request, row-major; a request is taken when
// start is high and busy is low, one per cycle while loading. Each request is
// insertion-sorted by magnitude into the cell row in the cycle it arrives.
// The request that completes the matrix (dim*dim entries) raises busy: the
// ST_RANK state picks the threshold magnitude from the row, then dim*dim
// results leave on rsp_*, one per cycle, each marked by a one-cycle
// rsp_valid strobe, the final one with rsp_last_of_run. The receiver cannot
// stall the block, so it must take every strobe. Results are read from a
// single tap at the last loaded cell of the entry shift line. No clearing
// pass is needed after reset.
module top_magnitude_matrix_sparsifier #(
   parameter int MAX_DIM    = tmms_pkg::DEF_MAX_DIM,
   parameter int VALUE_BITS = tmms_pkg::DEF_VALUE_BITS
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic [VALUE_BITS-1:0]       req_entry_value,
   output logic                        rsp_valid,
   output logic [VALUE_BITS-1:0]       rsp_kept_value,
   output logic                        rsp_last_of_run,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  tmms_pkg::csr_index_type     csr_index,
   input  logic [tmms_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import tmms_pkg::*;
   `include "top_magnitude_matrix_sparsifier_defines.svh"

   localparam int ENTRIES   = MAX_DIM * MAX_DIM;
   localparam int COUNT_W   = $clog2(ENTRIES + 1);
   localparam int MAG_W     = VALUE_BITS - 1;
   localparam int CMP_W     = (KEEP_W > COUNT_W) ? KEEP_W : COUNT_W;
   localparam int RESET_DIM = (DIM_RESET > MAX_DIM) ? MAX_DIM : DIM_RESET;
   localparam int RESET_ENTRIES = RESET_DIM * RESET_DIM;

   tmms_state_type state_ff, state_in;

   logic [COUNT_W-1:0] entries_ff, entries_in;
   logic [KEEP_W-1:0]  keep_ff, keep_in;
   logic [COUNT_W-1:0] load_cnt_ff, load_cnt_in;
   logic [COUNT_W-1:0] emit_cnt_ff, emit_cnt_in;
   logic [MAG_W-1:0]   thr_ff, thr_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [VALUE_BITS-1:0] rsp_value_ff, rsp_value_in;
   logic               rsp_last_ff, rsp_last_in;

   logic               accept;
   logic               csr_write;
   logic               restart;
   logic               shift_en;
   logic [MAG_W-1:0]   new_mag;
   logic [VALUE_BITS-1:0] neg_value;
   logic [DIM_W-1:0]   dim_clamped;
   logic [2*DIM_W-1:0] dim_square;
   logic [COUNT_W-1:0] last_idx;
   logic [CMP_W-1:0]   rank_full;
   logic [CMP_W-1:0]   rank_sel;
   logic [COUNT_W-1:0] rank_tap;
   logic [MAG_W-1:0]   rank_mag;
   logic [VALUE_BITS-1:0] tail_value;
   logic [MAG_W-1:0]   tail_mag;

   sort_flag_type         flag_chain  [ENTRIES+1];
   logic [MAG_W-1:0]      smag_chain  [ENTRIES+1];
   logic [VALUE_BITS-1:0] evalue_chain[ENTRIES+1];
   logic [MAG_W-1:0]      emag_chain  [ENTRIES+1];

   assign busy      = (state_ff != ST_LOAD);
   assign csr_ready = ~busy;
   assign accept    = start & ~busy;
   assign csr_write = csr_valid & csr_ready;
   assign restart   = (load_cnt_ff == '0);
   assign shift_en  = accept | (state_ff == ST_EMIT);

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_kept_value  = rsp_value_ff;
   assign rsp_last_of_run = rsp_last_ff;

   // Magnitude of the request; the most negative value saturates.
   always_comb begin
      neg_value = VALUE_BITS'(~req_entry_value + 1'b1);
      if (!req_entry_value[VALUE_BITS-1]) begin
         new_mag = req_entry_value[MAG_W-1:0];
      end else if (neg_value[VALUE_BITS-1]) begin
         new_mag = {MAG_W{1'b1}};
      end else begin
         new_mag = neg_value[MAG_W-1:0];
      end
   end

   // Head of the row: a valid, non-shifting source carrying the new request.
   assign flag_chain[0].valid = 1'b1;
   assign flag_chain[0].gt    = 1'b0;
   assign smag_chain[0]       = new_mag;
   assign evalue_chain[0]     = req_entry_value;
   assign emag_chain[0]       = new_mag;

   for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
      tmms_cell #(
         .VALUE_BITS(VALUE_BITS)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .restart     (restart),
         .insert      (accept),
         .shift_en    (shift_en),
         .new_mag     (new_mag),
         .up_flag     (flag_chain[i]),
         .up_sort_mag (smag_chain[i]),
         .dn_flag     (flag_chain[i+1]),
         .dn_sort_mag (smag_chain[i+1]),
         .up_ent_value(evalue_chain[i]),
         .up_ent_mag  (emag_chain[i]),
         .dn_ent_value(evalue_chain[i+1]),
         .dn_ent_mag  (emag_chain[i+1])
      );
   end

   // Rank index keep_count-1, saturated to the last loaded entry.
   assign last_idx  = entries_ff - 1'b1;
   assign rank_full = CMP_W'(keep_ff) - 1'b1;
   assign rank_sel  = (rank_full > CMP_W'(last_idx)) ? CMP_W'(last_idx) : rank_full;
   assign rank_tap  = COUNT_W'(rank_sel) + 1'b1;
   assign rank_mag  = smag_chain[rank_tap];

   // Oldest entry sits at the tap of the last loaded cell.
   assign tail_value = evalue_chain[entries_ff];
   assign tail_mag   = emag_chain[entries_ff];

   // Clamp the dimension to 1..MAX_DIM.
   always_comb begin
      dim_clamped = csr_wdata[DIM_W-1:0];
      if (dim_clamped == '0) begin
         dim_clamped = DIM_W'(1);
      end else if (dim_clamped > DIM_W'(MAX_DIM)) begin
         dim_clamped = DIM_W'(MAX_DIM);
      end
      dim_square = dim_clamped * dim_clamped;
   end

   always_comb begin
      state_in     = state_ff;
      entries_in   = entries_ff;
      keep_in      = keep_ff;
      load_cnt_in  = load_cnt_ff;
      emit_cnt_in  = emit_cnt_ff;
      thr_in       = thr_ff;
      rsp_valid_in = 1'b0;
      rsp_value_in = rsp_value_ff;
      rsp_last_in  = 1'b0;

      if (csr_write) begin
         case (csr_index)
            CSR_MATRIX_DIM: begin
               entries_in  = dim_square[COUNT_W-1:0];
               load_cnt_in = '0;
            end
            CSR_KEEP_COUNT: begin
               keep_in = csr_wdata[KEEP_W-1:0];
            end
            default: begin
            end
         endcase
      end

      case (state_ff)
         ST_LOAD: begin
            if (accept) begin
               // advance the fill count; the last entry starts the readout
               if (load_cnt_ff + 1'b1 == entries_ff) begin
                  load_cnt_in = '0;
                  state_in    = ST_RANK;
               end else begin
                  load_cnt_in = load_cnt_ff + 1'b1;
               end
            end
         end
         ST_RANK: begin
            thr_in      = (keep_ff <= KEEP_W'(1)) ? '0 : rank_mag;
            emit_cnt_in = '0;
            state_in    = ST_EMIT;
         end
         ST_EMIT: begin
            rsp_valid_in = 1'b1;
            rsp_value_in = (tail_mag >= thr_ff) ? tail_value : '0;
            rsp_last_in  = (emit_cnt_ff == last_idx);
            emit_cnt_in  = emit_cnt_ff + 1'b1;
            if (emit_cnt_ff == last_idx) begin
               state_in = ST_LOAD;
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         entries_ff   <= COUNT_W'(RESET_ENTRIES);
         keep_ff      <= KEEP_W'(KEEP_RESET);
         load_cnt_ff  <= '0;
         emit_cnt_ff  <= '0;
         rsp_valid_ff <= 1'b0;
         rsp_last_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         entries_ff   <= entries_in;
         keep_ff      <= keep_in;
         load_cnt_ff  <= load_cnt_in;
         emit_cnt_ff  <= emit_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         rsp_last_ff  <= rsp_last_in;
      end
      thr_ff       <= thr_in;
      rsp_value_ff <= rsp_value_in;
   end

   `TMMS_CHECK(a_fill_below_size, load_cnt_ff < entries_ff, "fill count reached matrix size")
   `TMMS_CHECK(a_rsp_from_emit, rsp_valid |-> $past(state_ff == ST_EMIT), "result outside readout")
   `TMMS_CHECK(a_last_frees, (rsp_valid && rsp_last_of_run) |-> !busy, "busy after final result")
   `TMMS_CHECK_NEXT(a_rank_then_emit, state_ff == ST_RANK, state_ff == ST_EMIT, "rank no readout")

endmodule

>>> tb/tb.sv
`timescale 1ns / 100ps
// Testbench for top_magnitude_matrix_sparsifier: directed table, then random matrices.
// Checks every result against an in-bench top-k magnitude predictor. Depends on tmms_pkg.
module tb;
   import tmms_pkg::*;

   localparam int VB           = DEF_VALUE_BITS;
   localparam int MAX_N        = DEF_MAX_DIM * DEF_MAX_DIM;
   localparam int RANDOM_ITEMS = 420;
   localparam int SETTLE       = 4;      // cycles the block may still work after its last result

   typedef enum logic {
      ROW_CSR,
      ROW_ENTRY
   } row_kind_type;

   // One row of the directed table: a register write or one entry request.
   // typed rows carry the single result of a one-entry matrix, read off by hand.
   typedef struct packed {
      row_kind_type        kind;
      csr_index_type       idx;
      logic [CSR_DATA_W-1:0] wdata;
      logic [VB-1:0]       value;
      logic                typed;
      logic [VB-1:0]       exp_value;
      logic                exp_last;
   } dir_row_type;

   typedef struct {
      logic [VB-1:0] kept_value;
      logic          last_of_run;
   } kept_item_type;

   localparam int DIR_ROWS = 30;
   localparam dir_row_type DIRECTED[DIR_ROWS] = '{
      // one-entry matrices: every entry is its own threshold, so each is kept
      '{ROW_CSR,   CSR_MATRIX_DIM, 7'd1,   32'h0,         1'b0, 32'h0,         1'b0},
      '{ROW_ENTRY, CSR_MATRIX_DIM, 7'd0,   32'h7FFF_FFFF, 1'b1, 32'h7FFF_FFFF, 1'b1},
      '{ROW_ENTRY, CSR_MATRIX_DIM, 7'd0,   32'h8000_0000, 1'b1, 32'h8000_0000, 1'b1},
      '{ROW_ENTRY, CSR_MATRIX_DIM, 7'd0,   32'h0000_0000, 1'b1, 32'h0000_0000, 1'b1},
      '{ROW_ENTRY, CSR_MATRIX_DIM, 7'd0,   32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF, 1'b1},
      // a dimension of zero acts as one
      '{ROW_CSR,   CSR_MATRIX_DIM, 7'd0,   32'h0,         1'b0, 32'h0,         1'b0},
      '{ROW_ENTRY, CSR_MATRIX_DIM, 7'd0,   32'h0001_0000, 1'b1, 32'h0001_0000, 1'b1},
      // keep nothing ranked: threshold zero keeps all four
      '{ROW_CSR,   CSR_KEEP_COUNT, 7'd0,   32'h0,         1'b0, 32'h0,         1'b0},
      '{ROW_CSR,   CSR_MATRIX_DIM, 7'd2,   32'h0,         1'b0, 32'h0,         1'b0},
      '{ROW_ENTRY, CSR_MATRIX_DIM, 7'd0,   32'h0001_8000, 1'b0, 32'h0,         1'b0},
      '{ROW_ENTRY, CSR_MATRIX_DIM, 7'd0,   32'hFFFE_8000, 1'b0, 32'h0,         1'b0},
      '{ROW_ENTRY, CSR_MATRIX_DIM, 7'd0,   32'h0000_0001, 1'b0, 32'h0,         1'b0},
      '{ROW_ENTRY, CSR_MATRIX_DIM, 7'd0,   32'hFFFF_FFFF, 1'b0, 32'h0,         1'b0},
      // saturated most negative value ties with the largest positive one
      '{ROW_CSR,   CSR_KEEP_COUNT, 7'd2,   32'h0,         1'b0, 32'h0,         1'b0},
      '{ROW_ENTRY, CSR_MATRIX_DIM, 7'd0,   32'h8000_0000, 1'b0, 32'h0,         1'b0},
      '{ROW_ENTRY, CSR_MATRIX_DIM, 7'd0,   32'h7FFF_FFFF, 1'b0, 32'h0,         1'b0},
      '{ROW_ENTRY, CSR_MATRIX_DIM, 7'd0,   32'h0000_0005, 1'b0, 32'h0,         1'b0},
      '{ROW_ENTRY, CSR_MATRIX_DIM, 7'd0,   32'hFFFF_FFFB, 1'b0, 32'h0,         1'b0},
      // rank past the end saturates to the smallest magnitude
      '{ROW_CSR,   CSR_KEEP_COUNT, 7'd127, 32'h0,         1'b0, 32'h0,         1'b0},
      '{ROW_ENTRY, CSR_MATRIX_DIM, 7'd0,   32'h1234_5678, 1'b0, 32'h0,         1'b0},
      '{ROW_ENTRY, CSR_MATRIX_DIM, 7'd0,   32'hEDCB_A988, 1'b0, 32'h0,         1'b0},
      '{ROW_ENTRY, CSR_MATRIX_DIM, 7'd0,   32'h0000_0000, 1'b0, 32'h0,         1'b0},
      '{ROW_ENTRY, CSR_MATRIX_DIM, 7'd0,   32'h0000_0003, 1'b0, 32'h0,         1'b0},
      // partial matrix, then a dimension write that drops it
      '{ROW_CSR,   CSR_KEEP_COUNT, 7'd3,   32'h0,         1'b0, 32'h0,         1'b0},
      '{ROW_ENTRY, CSR_MATRIX_DIM, 7'd0,   32'h0000_0002, 1'b0, 32'h0,         1'b0},
      '{ROW_ENTRY, CSR_MATRIX_DIM, 7'd0,   32'h0000_0007, 1'b0, 32'h0,         1'b0},
      '{ROW_CSR,   CSR_MATRIX_DIM, 7'd2,   32'h0,         1'b0, 32'h0,         1'b0},
      '{ROW_ENTRY, CSR_MATRIX_DIM, 7'd0,   32'h0000_0004, 1'b0, 32'h0,         1'b0},
      '{ROW_ENTRY, CSR_MATRIX_DIM, 7'd0,   32'hFFFF_FFF9, 1'b0, 32'h0,         1'b0},
      '{ROW_ENTRY, CSR_MATRIX_DIM, 7'd0,   32'h0000_0007, 1'b0, 32'h0,         1'b0}
   };

   logic                  clock;
   logic                  reset;
   logic                  start;
   logic                  busy;
   logic [VB-1:0]         req_entry_value;
   logic                  rsp_valid;
   logic [VB-1:0]         rsp_kept_value;
   logic                  rsp_last_of_run;
   logic                  csr_valid;
   logic                  csr_ready;
   csr_index_type         csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   // Predictor state: registers, the entries of the matrix being loaded, load position.
   logic [DIM_W-1:0]  dim_reg;
   logic [KEEP_W-1:0] keep_reg;
   logic [VB-1:0]     entry_mem [MAX_N];
   int                loaded;

   kept_item_type pending_kept[$];
   int         mismatches;
   int         rand_sent;

   top_magnitude_matrix_sparsifier dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_entry_value (req_entry_value),
      .rsp_valid       (rsp_valid),
      .rsp_kept_value  (rsp_kept_value),
      .rsp_last_of_run (rsp_last_of_run),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Hard stop well beyond the slowest correct run.
   initial begin
      #10_000_000;
      $display("Mismatches found");
      $finish;
   end

   task automatic report_mismatch(input string what, input logic [VB-1:0] got,
                                  input logic [VB-1:0] want);
      $display("result mismatch on %s at %0t: got %h, want %h", what, $time, got, want);
      mismatches++;
   endtask

   // Magnitude of a signed entry; the most negative value saturates.
   function automatic logic [VB-2:0] entry_magnitude(input logic [VB-1:0] v);
      logic [VB-1:0] neg;
      if (!v[VB-1]) return v[VB-2:0];
      neg = -v;
      if (neg[VB-1]) return '1;
      return neg[VB-2:0];
   endfunction

   // Dimension in use: clamp the register into 1..MAX_DIM.
   function automatic int dim_used();
      int d;
      d = int'(dim_reg);
      if (d < 1) d = 1;
      if (d > DEF_MAX_DIM) d = DEF_MAX_DIM;
      return d;
   endfunction

   // Take one accepted entry into the predictor. On the entry that completes the
   // matrix, rank all magnitudes, pick the threshold and queue every kept value.
   task automatic absorb_entry(input logic [VB-1:0] v, input logic typed,
                               input logic [VB-1:0] tv, input logic tl);
      int            n, r, i, j;
      logic [VB-2:0] mags [MAX_N];
      logic [VB-2:0] m, thr;
      kept_item_type item;
      n = dim_used() * dim_used();
      if (loaded >= n) loaded = 0;
      entry_mem[loaded] = v;
      loaded++;
      if (loaded < n) return;
      loaded = 0;
      // insertion sort, descending
      for (i = 0; i < n; i++) begin
         m = entry_magnitude(entry_mem[i]);
         j = i;
         while (j > 0 && mags[j-1] < m) begin
            mags[j] = mags[j-1];
            j--;
         end
         mags[j] = m;
      end
      if (keep_reg <= 1) begin
         thr = '0;
      end else begin
         r = int'(keep_reg) - 1;
         if (r > n - 1) r = n - 1;
         thr = mags[r];
      end
      if (typed) begin
         item.kept_value  = tv;
         item.last_of_run = tl;
         pending_kept.push_back(item);
      end else begin
         for (i = 0; i < n; i++) begin
            item.kept_value  = (entry_magnitude(entry_mem[i]) >= thr) ? entry_mem[i] : '0;
            item.last_of_run = (i == n - 1);
            pending_kept.push_back(item);
         end
      end
   endtask

   // Present one entry request after a gap; hold it until busy is low at an edge.
   task automatic send_entry(input logic [VB-1:0] v, input logic typed,
                             input logic [VB-1:0] tv, input logic tl, input int gap);
      @(negedge clock);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      start           <= 1'b1;
      req_entry_value <= v;
      do @(posedge clock); while (busy);
      absorb_entry(v, typed, tv, tl);
   endtask

   // Write one register once the block has drained every expected result.
   task automatic write_reg(input csr_index_type idx, input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      start <= 1'b0;
      while (pending_kept.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      if (idx == CSR_MATRIX_DIM) begin
         dim_reg = data[DIM_W-1:0];
         loaded  = 0;           // a dimension write drops the partial matrix
      end else begin
         keep_reg = data[KEEP_W-1:0];
      end
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Mix of full-range, tiny (many ties), extreme and scaled values.
   function automatic logic [VB-1:0] pick_value();
      logic [VB-1:0] v;
      case ($urandom_range(0, 9))
         4, 5: v = VB'($urandom_range(0, 16)) - VB'(8);
         6: begin
            case ($urandom_range(0, 4))
               0: v = 32'h8000_0000;
               1: v = 32'h7FFF_FFFF;
               2: v = 32'h0000_0000;
               3: v = 32'hFFFF_FFFF;
               default: v = 32'h8000_0001;
            endcase
         end
         7, 8, 9: begin
            v = $urandom >> $urandom_range(0, 31);
            if ($urandom_range(0, 1) != 0) v = -v;
         end
         default: v = $urandom;
      endcase
      return v;
   endfunction

   // Results come as one-cycle strobes; compare each with the oldest expectation.
   always @(posedge clock) begin : rsp_check
      kept_item_type want;
      if (!reset && rsp_valid) begin
         if (pending_kept.size() == 0) begin
            report_mismatch("unexpected result", rsp_kept_value, '0);
         end else begin
            want = pending_kept.pop_front();
            if (rsp_kept_value !== want.kept_value)
               report_mismatch("kept_value", rsp_kept_value, want.kept_value);
            if (rsp_last_of_run !== want.last_of_run)
               report_mismatch("last_of_run", VB'(rsp_last_of_run), VB'(want.last_of_run));
         end
      end
   end

   initial begin : stimulus
      int            row, n, mats, part, k, gap;
      logic          idle_on;
      logic [CSR_DATA_W-1:0] dim_w, keep_w;

      // Drive every input from time zero, with reset held high at the start.
      reset           = 1'b1;
      start           = 1'b0;
      req_entry_value = '0;
      csr_valid       = 1'b0;
      csr_index       = CSR_MATRIX_DIM;
      csr_wdata       = '0;
      dim_reg         = DIM_W'(DIM_RESET);
      keep_reg        = KEEP_W'(KEEP_RESET);
      loaded          = 0;
      mismatches      = 0;
      rand_sent       = 0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Walk the directed table.
      for (row = 0; row < DIR_ROWS; row++) begin
         if (DIRECTED[row].kind == ROW_CSR) begin
            write_reg(DIRECTED[row].idx, DIRECTED[row].wdata);
         end else begin
            send_entry(DIRECTED[row].value, DIRECTED[row].typed, DIRECTED[row].exp_value,
                       DIRECTED[row].exp_last, $urandom_range(0, 17));
         end
      end

      // Random phases: mostly whole matrices, sometimes a broken one left behind
      // for the next dimension write to drop, or to run on into the next phase.
      while (rand_sent < RANDOM_ITEMS) begin
         idle_on = ($urandom_range(0, 3) != 0);
         if ($urandom_range(0, 4) != 0) begin
            case ($urandom_range(0, 9))
               7: dim_w = CSR_DATA_W'($urandom_range(8, 15));
               8: dim_w = '0;
               9: dim_w = CSR_DATA_W'($urandom_range(0, 127));
               default: dim_w = CSR_DATA_W'($urandom_range(1, 4));
            endcase
            write_reg(CSR_MATRIX_DIM, dim_w);
         end
         n = dim_used() * dim_used();
         case ($urandom_range(0, 7))
            0: keep_w = CSR_DATA_W'($urandom_range(0, 1));
            1: keep_w = ($urandom_range(0, 1) != 0) ? CSR_DATA_W'(64) : CSR_DATA_W'(127);
            2: keep_w = CSR_DATA_W'($urandom_range(0, 127));
            default: keep_w = CSR_DATA_W'($urandom_range(0, n + 1));
         endcase
         if ($urandom_range(0, 5) != 0) write_reg(CSR_KEEP_COUNT, keep_w);
         mats = (n == MAX_N) ? 1 : $urandom_range(1, 3);
         part = ($urandom_range(0, 3) == 0 && n > 1) ? $urandom_range(1, n - 1) : 0;
         for (k = 0; k < mats * n + part; k++) begin
            gap = idle_on ? $urandom_range(0, 17) : 0;
            send_entry(pick_value(), 1'b0, '0, 1'b0, gap);
            rand_sent++;
         end
      end

      // Drop start, drain the expectations, then let the block settle.
      @(negedge clock);
      start <= 1'b0;
      while (pending_kept.size() != 0) @(posedge clock);
      repeat (2 * SETTLE) @(posedge clock);
      if (mismatches == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
